[rtl/core/pack_unit_vector_16bit_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the unit vector packer
// Shared property shapes, clocked on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PACK_UNIT_VECTOR_16BIT_UNIT_MACROS_SVH
`define PACK_UNIT_VECTOR_16BIT_UNIT_MACROS_SVH

// same-cycle implication
`define PUV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PUV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/puv16_pkg.sv]
// ----------------------------------------------------------------------------
// puv16_pkg
// Types and constants for the 16-bit compressed unit vector packer.
// ----------------------------------------------------------------------------
package puv16_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int QUOT_BITS       = 7;   // quotient range 0..126
    localparam int CODE_WIDTH      = 16;

    localparam logic [QUOT_BITS-1:0] PLANE_SUM  = QUOT_BITS'(126);
    localparam logic [QUOT_BITS-1:0] FOLD_LIMIT = QUOT_BITS'(64);
    localparam logic [QUOT_BITS-1:0] FOLD_BASE  = QUOT_BITS'(127);

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] comp_x;
        logic signed [COMPONENT_WIDTH-1:0] comp_y;
        logic signed [COMPONENT_WIDTH-1:0] comp_z;
    } puv16_in_t;

    typedef struct packed {
        logic [CODE_WIDTH-1:0] code;
        logic                  zero_vector;
    } puv16_out_t;

endpackage

[rtl/core/pack_unit_vector_16bit_unit.sv]
// Pipeline: capture, sum, 7 divide stages, pack, each one registered.
// Throughput: one vector per cycle while the output is not stalled; the restoring
// divider yields one quotient bit per stage for x and y in parallel.
// Each stage holds its item while the stage after it is full and stalled.
// Reset: aresetn synchronous, active low, clears all stage valid bits.
// ----------------------------------------------------------------------------
// pack_unit_vector_16bit_unit
// Packs a signed 3D direction into a 16-bit octant/triangle code.
// ----------------------------------------------------------------------------
`include "pack_unit_vector_16bit_unit_macros.svh"

module pack_unit_vector_16bit_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  puv16_pkg::puv16_in_t   s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output puv16_pkg::puv16_out_t  m_payload
);
    import puv16_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int SW = CW + 2;          // |x|+|y|+|z| <= 3*2^(CW-1)
    localparam int RW = CW + 7;          // holds 126*|a| and sum<<6
    localparam int QW = QUOT_BITS;

    // ------------------------------------------------------------------
    // Stage 0: sign/magnitude split
    // Magnitude is taken in CW unsigned bits, so the most negative
    // value maps to 2^(CW-1) exactly.
    // ------------------------------------------------------------------
    logic            s0_valid_reg;
    logic [CW-1:0]   s0_mag_x_reg, s0_mag_y_reg, s0_mag_z_reg;
    logic [2:0]      s0_sign_reg;
    logic            s0_ready;

    logic [CW-1:0]   raw_x, raw_y, raw_z;
    logic [CW-1:0]   mag_x_next, mag_y_next, mag_z_next;

    assign raw_x = s_payload.comp_x;
    assign raw_y = s_payload.comp_y;
    assign raw_z = s_payload.comp_z;

    assign mag_x_next = raw_x[CW-1] ? (~raw_x + CW'(1)) : raw_x;
    assign mag_y_next = raw_y[CW-1] ? (~raw_y + CW'(1)) : raw_y;
    assign mag_z_next = raw_z[CW-1] ? (~raw_z + CW'(1)) : raw_z;

    // ------------------------------------------------------------------
    // Divider pipeline. Index 0 is the sum/numerator stage; index j
    // (1..QW) has resolved quotient bit QW-j.
    // ------------------------------------------------------------------
    logic            dv_valid_reg [0:QW];
    logic [RW-1:0]   rem_x_reg    [0:QW];
    logic [RW-1:0]   rem_y_reg    [0:QW];
    logic [SW-1:0]   sum_reg      [0:QW];
    logic [QW-1:0]   qx_reg       [0:QW];
    logic [QW-1:0]   qy_reg       [0:QW];
    logic [2:0]      sign_reg     [0:QW];
    logic            zero_reg     [0:QW];
    logic            dv_ready     [0:QW];

    // Output register
    logic            m_valid_reg;
    puv16_out_t      m_payload_reg;
    logic            out_ready;

    // ------------------------------------------------------------------
    // Ready chain: a stage takes a new item when empty or when its
    // occupant moves on in the same cycle.
    // ------------------------------------------------------------------
    assign out_ready    = !m_valid_reg || m_ready;
    assign dv_ready[QW] = !dv_valid_reg[QW] || out_ready;

    for (genvar j = 0; j < QW; j++) begin : g_ready
        assign dv_ready[j] = !dv_valid_reg[j] || dv_ready[j+1];
    end

    assign s0_ready = !s0_valid_reg || dv_ready[0];
    assign s_ready  = s0_ready;

    // Stage 0 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_ready) begin
            s0_valid_reg <= s_valid;
        end
        if (s0_ready && s_valid) begin
            s0_mag_x_reg <= mag_x_next;
            s0_mag_y_reg <= mag_y_next;
            s0_mag_z_reg <= mag_z_next;
            s0_sign_reg  <= {raw_x[CW-1], raw_y[CW-1], raw_z[CW-1]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: plane sum and numerators 126*|x|, 126*|y|
    // ------------------------------------------------------------------
    logic [SW-1:0] sum_next;
    logic [RW-1:0] num_x_next, num_y_next;

    assign sum_next   = SW'(s0_mag_x_reg) + SW'(s0_mag_y_reg) + SW'(s0_mag_z_reg);
    assign num_x_next = RW'(s0_mag_x_reg) * RW'(PLANE_SUM);
    assign num_y_next = RW'(s0_mag_y_reg) * RW'(PLANE_SUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (dv_ready[0]) begin
            dv_valid_reg[0] <= s0_valid_reg;
        end
        if (dv_ready[0] && s0_valid_reg) begin
            rem_x_reg[0] <= num_x_next;
            rem_y_reg[0] <= num_y_next;
            sum_reg[0]   <= sum_next;
            qx_reg[0]    <= '0;
            qy_reg[0]    <= '0;
            sign_reg[0]  <= s0_sign_reg;
            zero_reg[0]  <= (sum_next == '0);
        end
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage, MSB first.
    // Quotient never exceeds 126, so seven bits cover it. A zero sum
    // yields junk here; the pack stage masks it.
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= QW; j++) begin : g_div
        localparam int BIT = QW - j;

        logic [RW-1:0] trial;
        logic          ge_x, ge_y;

        assign trial = RW'(sum_reg[j-1]) << BIT;
        assign ge_x  = (rem_x_reg[j-1] >= trial);
        assign ge_y  = (rem_y_reg[j-1] >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j] <= 1'b0;
            end else if (dv_ready[j]) begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
            if (dv_ready[j] && dv_valid_reg[j-1]) begin
                rem_x_reg[j] <= ge_x ? (rem_x_reg[j-1] - trial) : rem_x_reg[j-1];
                rem_y_reg[j] <= ge_y ? (rem_y_reg[j-1] - trial) : rem_y_reg[j-1];
                qx_reg[j]    <= {qx_reg[j-1][QW-2:0], ge_x};
                qy_reg[j]    <= {qy_reg[j-1][QW-2:0], ge_y};
                sum_reg[j]   <= sum_reg[j-1];
                sign_reg[j]  <= sign_reg[j-1];
                zero_reg[j]  <= zero_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pack stage: fold upper triangle (xq >= 64) as 127-v, then
    // {signs, x[5:0], y[6:0]}. Zero vector forces code 0.
    // ------------------------------------------------------------------
    logic [QW-1:0] qx_fin, qy_fin;
    logic          fold;
    logic [QW-1:0] fx, fy;
    puv16_out_t    pack_next;

    assign qx_fin = qx_reg[QW];
    assign qy_fin = qy_reg[QW];
    assign fold   = (qx_fin >= FOLD_LIMIT);
    assign fx     = fold ? (FOLD_BASE - qx_fin) : qx_fin;
    assign fy     = fold ? (FOLD_BASE - qy_fin) : qy_fin;

    always_comb begin
        pack_next.zero_vector = zero_reg[QW];
        if (zero_reg[QW]) begin
            pack_next.code = '0;
        end else begin
            pack_next.code = {sign_reg[QW], fx[QW-2:0], fy};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= dv_valid_reg[QW];
        end
        if (out_ready && dv_valid_reg[QW]) begin
            m_payload_reg <= pack_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // x and y shares of the plane never exceed the plane sum together
    `PUV_ASSERT_SAME(a_quot_sum, dv_valid_reg[QW] && !zero_reg[QW], (8'(qx_fin) + 8'(qy_fin)) <= 8'(PLANE_SUM), "quotients exceed plane sum")
    // division fully resolved: remainders below divisor
    `PUV_ASSERT_SAME(a_rem_low, dv_valid_reg[QW] && !zero_reg[QW], (rem_x_reg[QW] < RW'(sum_reg[QW])) && (rem_y_reg[QW] < RW'(sum_reg[QW])), "divider remainder not below sum")
    // a finished quotient moving into the output register shows up as valid
    `PUV_ASSERT_NEXT(a_out_load, dv_valid_reg[QW] && out_ready, m_valid_reg, "output stage lost an item")
    // zero vector always carries an all-zero code
    `PUV_ASSERT_SAME(a_zero_code, m_valid && m_payload.zero_vector, m_payload.code == '0, "zero vector with nonzero code")

endmodule

[tb/sv/pack_unit_vector_16bit_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pack_unit_vector_16bit_unit_test
// Self-checking bench for the 16-bit unit vector packer. A table of directed
// vectors runs first, then a long random stream. Every result transfer is
// compared field by field with an in-order queue of predicted codes.
// ----------------------------------------------------------------------------
module pack_unit_vector_16bit_unit_test;

    import puv16_pkg::*;

    localparam int RANDOM_VECTORS = 1900;
    localparam int PHASE_LENGTH   = 100;   // idle odds are redrawn per phase
    localparam int TAIL_VECTORS   = 200;   // no idling on either side here
    localparam int DRAIN_CYCLES   = 20;    // extra wait for stray results after the queue empties
    localparam int CYCLE_LIMIT    = 400000;
    localparam int N_DIRECTED     = 20;

    // One directed row: the vector, and a hand-typed expected result where
    // known_result is set. Other rows go through the predictor.
    typedef struct packed {
        puv16_in_t  vec;
        logic       known_result;
        puv16_out_t result;
    } direction_row_t;

    // Expected codes: axis-aligned cases, the all-zero vector, the signed
    // extremes, and the balanced diagonal (126/3 = 42 on both fields).
    localparam direction_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b1, '{16'h0000, 1'b1}},  // zero vector
        '{'{16'sh0001, 16'sh0000, 16'sh0000}, 1'b1, '{16'h00FF, 1'b0}},  // lone x folds
        '{'{16'sh7FFF, 16'sh0000, 16'sh0000}, 1'b1, '{16'h00FF, 1'b0}},
        '{'{16'sh8000, 16'sh0000, 16'sh0000}, 1'b1, '{16'h80FF, 1'b0}},  // most negative x
        '{'{16'sh0000, 16'sh0001, 16'sh0000}, 1'b1, '{16'h007E, 1'b0}},  // lone y
        '{'{16'sh0000, 16'sh8000, 16'sh0000}, 1'b1, '{16'h407E, 1'b0}},
        '{'{16'sh0000, 16'sh0000, 16'sh7FFF}, 1'b1, '{16'h0000, 1'b0}},  // lone z
        '{'{16'sh0000, 16'sh0000, 16'shFFFF}, 1'b1, '{16'h2000, 1'b0}},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1, '{16'hF52A, 1'b0}},  // all at min
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1, '{16'h152A, 1'b0}},  // all at max
        '{'{16'sh0001, 16'sh0001, 16'sh0000}, 1'b1, '{16'h1FBF, 1'b0}},  // xq 63, no fold
        '{'{16'sh0040, 16'sh003E, 16'sh0000}, 1'b0, '{16'h0000, 1'b0}},  // xq 64, first fold
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh7FFF, 16'sh8000, 16'sh0001}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh0064, 16'shFFFD, 16'sh0007}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh0000, 16'sh8000, 16'sh7FFF}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'shFFFB, 16'sh0000, 16'sh0000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh5555, 16'sh5555, 16'sh5556}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'sh5555, 16'shAAAA, 16'sh0000}, 1'b0, '{16'h0000, 1'b0}}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    puv16_in_t  s_payload;
    logic       m_valid;
    logic       m_ready;
    puv16_out_t m_payload;

    // Predicted results, oldest first.
    puv16_out_t expected_codes [$];
    int         fail_count;

    // Idle control for the source and the sink.
    int         source_idle_odds;   // out of 8, 0 = never idle
    int         sink_stall_odds;    // out of 8, 0 = never stall
    logic       quiet_tail;

    pack_unit_vector_16bit_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Exact magnitude of a two's complement component; -32768 gives 32768.
    function automatic logic [16:0] magnitude_of(input logic [15:0] raw);
        if (raw[15]) begin
            return 17'h10000 - {1'b0, raw};
        end
        return {1'b0, raw};
    endfunction

    // Octant signs on top, then the plane projection onto x+y+z = 126,
    // folded about xq = 64 so the triangle fits a 6 x 7 bit rectangle.
    function automatic puv16_out_t pack_direction(input puv16_in_t vec);
        logic [16:0] mag_x;
        logic [16:0] mag_y;
        logic [16:0] mag_z;
        logic [22:0] mag_sum;
        logic [6:0]  quot_x;
        logic [6:0]  quot_y;
        puv16_out_t  packed_dir;
        mag_x   = magnitude_of(vec.comp_x);
        mag_y   = magnitude_of(vec.comp_y);
        mag_z   = magnitude_of(vec.comp_z);
        mag_sum = 23'(mag_x) + 23'(mag_y) + 23'(mag_z);
        if (mag_sum == '0) begin
            packed_dir.code        = '0;
            packed_dir.zero_vector = 1'b1;
            return packed_dir;
        end
        // 126 * 32768 stays below 2^22, so 23 bits hold the numerator
        quot_x = 7'((23'(PLANE_SUM) * 23'(mag_x)) / mag_sum);
        quot_y = 7'((23'(PLANE_SUM) * 23'(mag_y)) / mag_sum);
        if (quot_x >= FOLD_LIMIT) begin
            quot_x = FOLD_BASE - quot_x;
            quot_y = FOLD_BASE - quot_y;
        end
        packed_dir.code = {vec.comp_x[15], vec.comp_y[15], vec.comp_z[15],
                           quot_x[5:0], quot_y};
        packed_dir.zero_vector = 1'b0;
        return packed_dir;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset default, timeout
    // ------------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop: far above the slowest legal run (every vector waiting out a
    // full source gap and a full sink stall on top of the pipe latency).
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink: m_ready drops low in random bursts. Exactly one
    // assignment per falling edge, so no same-step glitch on m_ready.
    // ------------------------------------------------------------------------

    initial begin : sink_stall
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!quiet_tail && sink_stall_odds != 0 &&
                $urandom_range(1, 8) <= sink_stall_odds) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sampled at the rising edge, in order against the queue.
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin : result_check
        puv16_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected result transfer: code %h zero_vector %b",
                       m_payload.code, m_payload.zero_vector);
                fail_count++;
            end else begin
                want = expected_codes.pop_front();
                if (m_payload.code !== want.code) begin
                    $error("code mismatch: expected %h, actual %h",
                           want.code, m_payload.code);
                    fail_count++;
                end
                if (m_payload.zero_vector !== want.zero_vector) begin
                    $error("zero_vector mismatch: expected %b, actual %b",
                           want.zero_vector, m_payload.zero_vector);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source
    // ------------------------------------------------------------------------

    // Called at a falling edge. Optional idle gap first, then the vector is
    // held until the transfer, and the task returns at the next falling edge.
    task automatic send_vector(input puv16_in_t vec, input puv16_out_t outcome);
        int gap;
        gap = 0;
        if (!quiet_tail && source_idle_odds != 0 &&
            $urandom_range(1, 8) <= source_idle_odds) begin
            gap = $urandom_range(1, 13);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_payload <= vec;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_codes.push_back(outcome);
        @(negedge aclk);
    endtask

    // Per-component shapes: mostly full-range noise, plus small values near
    // zero (fold edges, zero vectors), extremes, large magnitudes and exact zeros.
    function automatic logic [15:0] pick_component(input int shape);
        logic [15:0] mag;
        case (shape)
            5, 6: begin
                return 16'(int'($urandom_range(0, 16)) - 8);
            end
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            8: begin
                mag = 16'($urandom_range(16384, 32767));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            9: begin
                return 16'h0000;
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // Pause the source until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        puv16_in_t  vec;
        puv16_out_t outcome;
        int         tiny;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_payload        = '0;
        fail_count       = 0;
        source_idle_odds = 2;
        sink_stall_odds  = 2;
        quiet_tail       = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        for (int row = 0; row < N_DIRECTED; row++) begin
            vec = DIRECTED_ROWS[row].vec;
            if (DIRECTED_ROWS[row].known_result) begin
                outcome = DIRECTED_ROWS[row].result;
            end else begin
                outcome = pack_direction(vec);
            end
            send_vector(vec, outcome);
        end

        // Source holds off until the pipe is empty, then restarts from idle.
        drain_results();
        @(negedge aclk);

        // Random stream
        for (int n = 0; n < RANDOM_VECTORS; n++) begin
            if (n % PHASE_LENGTH == 0) begin
                source_idle_odds = $urandom_range(0, 4);
                sink_stall_odds  = $urandom_range(0, 4);
            end
            if (n == RANDOM_VECTORS / 2) begin
                drain_results();
                @(negedge aclk);
            end
            if (n == RANDOM_VECTORS - TAIL_VECTORS) begin
                quiet_tail = 1'b1;
            end

            // one vector in sixteen stays within -2..2 on all axes
            tiny = ($urandom_range(0, 15) == 0);
            if (tiny) begin
                vec.comp_x = 16'(int'($urandom_range(0, 4)) - 2);
                vec.comp_y = 16'(int'($urandom_range(0, 4)) - 2);
                vec.comp_z = 16'(int'($urandom_range(0, 4)) - 2);
            end else begin
                vec.comp_x = pick_component($urandom_range(0, 9));
                vec.comp_y = pick_component($urandom_range(0, 9));
                vec.comp_z = pick_component($urandom_range(0, 9));
            end
            send_vector(vec, pack_direction(vec));
        end

        // Wind down: wait out the queue, then DRAIN_CYCLES more for strays.
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
